[rtl/core/bfa_pkg.sv]
// Package: shared constants, command codes and word-unit control types for the frame allocator.
package bfa_pkg;

  // Default sizing of the frame map
  localparam int DEF_MAX_FRAMES    = 65536;
  localparam int DEF_FRAME_BYTES   = 4096;
  localparam int DEF_MAP_WORD_BITS = 64;

  // Fixed field widths of the channels and the register
  localparam int CMD_W  = 2;
  localparam int ADDR_W = 32;
  localparam int LEN_W  = 32;
  localparam int FREE_W = 17;
  localparam int CFG_W  = 17;

  // Widest bit index inside one map word (words up to 64 bits)
  localparam int BIT_IDX_W = 6;

  localparam logic [CFG_W-1:0] CFG_RESET = 17'd65536;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RESERVE = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_t;

  // Operation applied to one map word
  typedef enum logic [1:0] {
    WOP_SET,
    WOP_CLEAR,
    WOP_ALLOC
  } wop_t;

  typedef struct packed {
    wop_t                 op;
    logic                 first;  // word holds the first frame of the span
    logic                 last;   // word holds the last frame of the span
    logic [BIT_IDX_W-1:0] lo;     // first bit, used when first is set
    logic [BIT_IDX_W-1:0] hi;     // last bit, used when last is set
  } word_ctl_t;

endpackage

[rtl/core/bfa_if.sv]
// Interfaces: request and response channels of the frame allocator.
interface bfa_req_if import bfa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] base_address;
  logic [LEN_W-1:0]  range_length;

  modport source(output valid, output command, output base_address, output range_length,
                 input ready);
  modport sink(input valid, input command, input base_address, input range_length,
               output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] frame_address;
  logic              ok;
  logic [FREE_W-1:0] free_frames;

  modport source(output valid, output frame_address, output ok, output free_frames,
                 input ready);
  modport sink(input valid, input frame_address, input ok, input free_frames,
               output ready);
endinterface

[rtl/core/bitmap_frame_allocator.sv]
// Top level: bitmap frame allocator with word-walking sequencer over the used-map RAM.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-------------------------------------------
//  in_chan | in  | valid / ready     | command, base_address, range_length
//  out_chan| out | valid / ready     | frame_address, ok, free_frames
//  cfg_    | in  | cfg_wr_en         | cfg_wr_data = frame limit
//
// A request is set up and clipped, then each map word visited takes one RAM read,
// then one read-modify-write through the word unit: alloc walks from word 0
// up to the word of the first free frame, range and free commands walk the
// words they span. After reset a clearing pass writes every map word to used
// (1024 words by default), while in_chan.ready stays low.
// A stalled result is held in the output register; the next request is taken
// meanwhile and waits to finish until the output register frees up.
module bitmap_frame_allocator import bfa_pkg::*; #(
  parameter int MAX_FRAMES    = DEF_MAX_FRAMES,
  parameter int FRAME_BYTES   = DEF_FRAME_BYTES,
  parameter int MAP_WORD_BITS = DEF_MAP_WORD_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  bfa_req_if.sink          in_chan,
  bfa_rsp_if.source        out_chan,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  localparam int WS        = $clog2(MAP_WORD_BITS);
  localparam int MAP_WORDS = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WI_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int FI_W      = WI_W + WS;
  localparam int FBS       = $clog2(FRAME_BYTES);
  localparam int FT_W      = $clog2(MAX_FRAMES + 1);
  localparam int CNT_W     = $clog2(MAP_WORD_BITS + 1);
  localparam logic [33:0]   LIM_MAX   = 34'(MAX_FRAMES);
  localparam logic [33:0]   FB_M1     = 34'(FRAME_BYTES - 1);
  localparam logic [WI_W-1:0] LAST_WORD = WI_W'(MAP_WORDS - 1);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_SETUP,
    S_CLIP,
    S_RD,
    S_MOD,
    S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [WI_W-1:0]     cur_w_r, cur_w_nxt;
  logic [FT_W-1:0]     free_total_r, free_total_nxt;
  logic [CFG_W-1:0]    cfg_r, cfg_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic [FREE_W-1:0]   out_free_r, out_free_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  wop_t                wop_r, wop_nxt;
  logic [33:0]         first_raw_r, first_raw_nxt;
  logic [33:0]         end_raw_r, end_raw_nxt;
  logic [FI_W-1:0]     first_r, first_nxt;
  logic [FI_W-1:0]     last_r, last_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  logic                res_ok_r, res_ok_nxt;

  logic [33:0]              lim;
  logic [33:0]              base34;
  logic [33:0]              top34;
  logic [33:0]              end_c;
  logic [33:0]              last34;
  logic                     ram_wr_en;
  logic [WI_W-1:0]          ram_wr_addr;
  logic [MAP_WORD_BITS-1:0] ram_wr_data;
  logic                     ram_rd_en;
  logic [MAP_WORD_BITS-1:0] ram_rd_data;
  word_ctl_t                wctl;
  logic [MAP_WORD_BITS-1:0] new_word;
  logic [CNT_W-1:0]         changed_cnt;
  logic                     found;
  logic [WS-1:0]            found_idx;
  logic [FI_W-1:0]          found_frame;

  // Effective frame limit
  assign lim = (34'(cfg_r) >= LIM_MAX) ? LIM_MAX : 34'(cfg_r);

  // Span arithmetic
  assign base34 = 34'(base_r);
  assign top34  = base34 + 34'(len_r);
  assign end_c  = (end_raw_r > lim) ? lim : end_raw_r;
  assign last34 = end_c - 34'd1;

  // Word unit control for the current word
  always_comb begin
    wctl       = '0;
    wctl.op    = wop_r;
    wctl.first = (cur_w_r == first_r[FI_W-1:WS]);
    wctl.last  = (cur_w_r == last_r[FI_W-1:WS]);
    wctl.lo    = BIT_IDX_W'(first_r[WS-1:0]);
    wctl.hi    = BIT_IDX_W'(last_r[WS-1:0]);
  end

  assign found_frame = {cur_w_r, found_idx};

  bfa_word_unit #(
    .WORD_BITS(MAP_WORD_BITS)
  ) u_word (
    .old_word   (ram_rd_data),
    .ctl        (wctl),
    .new_word   (new_word),
    .changed_cnt(changed_cnt),
    .found      (found),
    .found_idx  (found_idx)
  );

  bfa_ram #(
    .WIDTH(MAP_WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(cur_w_r),
    .rd_data(ram_rd_data)
  );

  assign ram_wr_addr = cur_w_r;
  assign ram_wr_data = (state_r == S_CLR) ? {MAP_WORD_BITS{1'b1}} : new_word;
  assign ram_wr_en   = (state_r == S_CLR) ||
                       ((state_r == S_MOD) && ((wop_r != WOP_ALLOC) || found));
  assign ram_rd_en   = (state_r == S_RD);

  assign in_chan.ready = (state_r == S_IDLE);

  assign out_chan.valid         = out_valid_r;
  assign out_chan.frame_address = out_addr_r;
  assign out_chan.ok            = out_ok_r;
  assign out_chan.free_frames   = out_free_r;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    cur_w_nxt      = cur_w_r;
    free_total_nxt = free_total_r;
    cfg_nxt        = cfg_wr_en ? cfg_wr_data : cfg_r;
    out_valid_nxt  = out_valid_r;
    out_addr_nxt   = out_addr_r;
    out_ok_nxt     = out_ok_r;
    out_free_nxt   = out_free_r;
    cmd_nxt        = cmd_r;
    base_nxt       = base_r;
    len_nxt        = len_r;
    wop_nxt        = wop_r;
    first_raw_nxt  = first_raw_r;
    end_raw_nxt    = end_raw_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    res_addr_nxt   = res_addr_r;
    res_ok_nxt     = res_ok_r;

    // Drop the result once taken
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        if (cur_w_r == LAST_WORD) begin
          cur_w_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          cur_w_nxt = cur_w_r + WI_W'(1);
        end
      end
      S_IDLE: begin
        if (in_chan.valid) begin
          cmd_nxt   = cmd_t'(in_chan.command);
          base_nxt  = in_chan.base_address;
          len_nxt   = in_chan.range_length;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        unique case (cmd_r)
          CMD_ALLOC: begin
            wop_nxt       = WOP_ALLOC;
            first_raw_nxt = '0;
            end_raw_nxt   = lim;
          end
          CMD_FREE: begin
            wop_nxt       = WOP_CLEAR;
            first_raw_nxt = base34 >> FBS;
            end_raw_nxt   = (base34 >> FBS) + 34'd1;
          end
          CMD_RESERVE: begin
            wop_nxt       = WOP_SET;
            first_raw_nxt = base34 >> FBS;
            end_raw_nxt   = (top34 + FB_M1) >> FBS;
          end
          CMD_RELEASE: begin
            wop_nxt       = WOP_CLEAR;
            first_raw_nxt = (base34 + FB_M1) >> FBS;
            end_raw_nxt   = top34 >> FBS;
          end
          default: begin
            wop_nxt       = WOP_CLEAR;
            first_raw_nxt = '0;
            end_raw_nxt   = '0;
          end
        endcase
        state_nxt = S_CLIP;
      end
      S_CLIP: begin
        res_addr_nxt = '0;
        res_ok_nxt   = 1'b0;
        first_nxt    = first_raw_r[FI_W-1:0];
        last_nxt     = last34[FI_W-1:0];
        cur_w_nxt    = first_raw_r[FI_W-1:WS];
        // Skip empty or inverted spans
        if (first_raw_r >= end_c) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_MOD;
      end
      S_MOD: begin
        unique case (wop_r)
          WOP_ALLOC: begin
            if (found) begin
              free_total_nxt = free_total_r - FT_W'(1);
              res_addr_nxt   = ADDR_W'({found_frame, {FBS{1'b0}}});
              res_ok_nxt     = 1'b1;
            end
          end
          WOP_SET: begin
            free_total_nxt = free_total_r - FT_W'(changed_cnt);
          end
          WOP_CLEAR: begin
            free_total_nxt = free_total_r + FT_W'(changed_cnt);
            res_ok_nxt     = (cmd_r == CMD_FREE) && (changed_cnt != '0);
          end
          default: begin
            free_total_nxt = free_total_r;
          end
        endcase
        // Advance to the next word or finish
        if (((wop_r == WOP_ALLOC) && found) || wctl.last) begin
          state_nxt = S_OUT;
        end else begin
          cur_w_nxt = cur_w_r + WI_W'(1);
          state_nxt = S_RD;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r;
          out_ok_nxt    = res_ok_r;
          out_free_nxt  = FREE_W'(free_total_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      cur_w_r      <= '0;
      free_total_r <= '0;
      cfg_r        <= CFG_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_w_r      <= cur_w_nxt;
      free_total_r <= free_total_nxt;
      cfg_r        <= cfg_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_addr_r  <= out_addr_nxt;
    out_ok_r    <= out_ok_nxt;
    out_free_r  <= out_free_nxt;
    cmd_r       <= cmd_nxt;
    base_r      <= base_nxt;
    len_r       <= len_nxt;
    wop_r       <= wop_nxt;
    first_raw_r <= first_raw_nxt;
    end_raw_r   <= end_raw_nxt;
    first_r     <= first_nxt;
    last_r      <= last_nxt;
    res_addr_r  <= res_addr_nxt;
    res_ok_r    <= res_ok_nxt;
  end

  // Free count never exceeds the map size
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_total_r <= FT_W'(MAX_FRAMES))
    else $error("free count above map size");

  // Free count moves only on a word update
  a_free_stable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_MOD |=> $stable(free_total_r))
    else $error("free count changed outside a word update");

  // Word walk never passes the last word of the span
  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |-> cur_w_r <= last_r[FI_W-1:WS])
    else $error("word walk beyond span");

endmodule

[rtl/core/bfa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/bfa_word_unit.sv]
// Shared word unit: span mask, set/clear/first-free update and changed-bit count of one map word.
module bfa_word_unit import bfa_pkg::*; #(
  parameter int WORD_BITS = DEF_MAP_WORD_BITS
) (
  input  logic [WORD_BITS-1:0]             old_word,
  input  word_ctl_t                        ctl,
  output logic [WORD_BITS-1:0]             new_word,
  output logic [$clog2(WORD_BITS+1)-1:0]   changed_cnt,
  output logic                             found,
  output logic [$clog2(WORD_BITS)-1:0]     found_idx
);

  localparam int WS = $clog2(WORD_BITS);
  localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

  logic [WS-1:0]        lo;
  logic [WS-1:0]        hi;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] low_oh;
  logic [WORD_BITS-1:0] changed;

  assign lo = ctl.lo[WS-1:0];
  assign hi = ctl.hi[WS-1:0];

  // Bits of this word that lie inside the span
  assign mask = (ctl.first ? (ALL_ONES << lo) : ALL_ONES) &
                (ctl.last  ? (ALL_ONES >> (~hi)) : ALL_ONES);

  // Free bits inside the span, and the lowest of them as a one-hot
  assign cand   = mask & ~old_word;
  assign low_oh = cand & (~cand + WORD_BITS'(1));
  assign found  = |cand;

  // Encode the one-hot position
  always_comb begin
    found_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low_oh[i]) begin
        found_idx = found_idx | WS'(i);
      end
    end
  end

  // Apply the operation
  always_comb begin
    unique case (ctl.op)
      WOP_SET: begin
        changed  = cand;
        new_word = old_word | mask;
      end
      WOP_CLEAR: begin
        changed  = mask & old_word;
        new_word = old_word & ~mask;
      end
      WOP_ALLOC: begin
        changed  = low_oh;
        new_word = old_word | low_oh;
      end
      default: begin
        changed  = '0;
        new_word = old_word;
      end
    endcase
  end

  assign changed_cnt = ($clog2(WORD_BITS+1))'($countones(changed));

endmodule

[bench/frame_map_checker.sv]
// Checker: watches the allocator channels, predicts each response and compares it.
`timescale 1ns / 1ps

module frame_map_checker import bfa_pkg::*; #(
  parameter int MAX_FRAMES  = DEF_MAX_FRAMES,
  parameter int FRAME_BYTES = DEF_FRAME_BYTES,
  parameter int WORD_BITS   = DEF_MAP_WORD_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  bfa_req_if               req_mon,
  bfa_rsp_if               rsp_mon,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  output int               mismatch_count,
  output int               responses_due
);

  localparam int MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;

  typedef struct packed {
    logic [ADDR_W-1:0] frame_address;
    logic              ok;
    logic [FREE_W-1:0] free_frames;
  } frame_response_t;

  // Shadow copy of the used map, the free count and the managed-frame register
  logic [WORD_BITS-1:0] used_words [MAP_WORDS];
  longint unsigned      free_count;
  logic [CFG_W-1:0]     managed_frames;
  frame_response_t      awaited_responses [$];
  frame_response_t      seen_rsp;
  int                   errors = 0;

  function automatic longint unsigned frame_limit();
    return (managed_frames < MAX_FRAMES) ? 64'(managed_frames) : 64'(MAX_FRAMES);
  endfunction

  function automatic bit frame_used(input longint unsigned f);
    return used_words[f / WORD_BITS][f % WORD_BITS];
  endfunction

  // Set or clear one frame; count only real changes
  function automatic bit mark_frame(input longint unsigned f, input bit used);
    if (frame_used(f) == used) return 1'b0;
    used_words[f / WORD_BITS][f % WORD_BITS] = used;
    if (used) free_count--;
    else free_count++;
    return 1'b1;
  endfunction

  // Mark frames [first, stop) with stop clipped at the managed limit
  function automatic void mark_span(input longint unsigned first, input longint unsigned stop,
                                    input bit used);
    longint unsigned lim;
    longint unsigned f;
    lim = frame_limit();
    if (stop > lim) stop = lim;
    for (f = first; f < stop; f++) void'(mark_frame(f, used));
  endfunction

  function automatic frame_response_t predict_frame_response(input cmd_t cmd,
                                                             input logic [ADDR_W-1:0] base,
                                                             input logic [LEN_W-1:0] len);
    frame_response_t rsp;
    longint unsigned lim;
    longint unsigned span_end;
    longint unsigned nwords;
    longint unsigned f;
    longint unsigned w;
    longint unsigned b;
    bit              found;
    rsp      = '0;
    found    = 1'b0;
    lim      = frame_limit();
    span_end = 64'(base) + 64'(len);
    case (cmd)
      CMD_ALLOC: begin
        // Take the lowest free frame below the limit, skipping full words
        nwords = (lim + WORD_BITS - 1) / WORD_BITS;
        for (w = 0; w < nwords && !found; w++) begin
          if (&used_words[w]) continue;
          for (b = 0; b < WORD_BITS && !found; b++) begin
            f = w * WORD_BITS + b;
            if (f >= lim) break;
            if (!frame_used(f)) begin
              void'(mark_frame(f, 1'b1));
              rsp.frame_address = ADDR_W'(f * FRAME_BYTES);
              rsp.ok            = 1'b1;
              found             = 1'b1;
            end
          end
        end
      end
      CMD_FREE: begin
        f = 64'(base) / FRAME_BYTES;
        if (f < lim) rsp.ok = mark_frame(f, 1'b0);
      end
      // Reserve rounds outward, release rounds inward
      CMD_RESERVE: mark_span(64'(base) / FRAME_BYTES,
                             (span_end + FRAME_BYTES - 1) / FRAME_BYTES, 1'b1);
      CMD_RELEASE: mark_span((64'(base) + FRAME_BYTES - 1) / FRAME_BYTES,
                             span_end / FRAME_BYTES, 1'b0);
      default: ;
    endcase
    rsp.free_frames = FREE_W'(free_count);
    return rsp;
  endfunction

  function automatic void check_response(input frame_response_t want, input frame_response_t got);
    if (got.frame_address !== want.frame_address) begin
      $error("frame_address: expected %h, actual %h", want.frame_address, got.frame_address);
      errors++;
    end
    if (got.ok !== want.ok) begin
      $error("ok: expected %b, actual %b", want.ok, got.ok);
      errors++;
    end
    if (got.free_frames !== want.free_frames) begin
      $error("free_frames: expected %0d, actual %0d", want.free_frames, got.free_frames);
      errors++;
    end
  endfunction

  // Track register writes, check responses, then predict newly taken requests
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (used_words[i]) used_words[i] = '1;
      free_count     = 0;
      managed_frames = CFG_RESET;
      awaited_responses.delete();
    end else begin
      if (cfg_wr_en) managed_frames = cfg_wr_data;
      if (rsp_mon.valid && rsp_mon.ready) begin
        seen_rsp.frame_address = rsp_mon.frame_address;
        seen_rsp.ok            = rsp_mon.ok;
        seen_rsp.free_frames   = rsp_mon.free_frames;
        if (awaited_responses.size() == 0) begin
          $error("response with no request outstanding: frame_address %h ok %b free_frames %0d",
                 seen_rsp.frame_address, seen_rsp.ok, seen_rsp.free_frames);
          errors++;
        end else begin
          check_response(awaited_responses.pop_front(), seen_rsp);
        end
      end
      if (req_mon.valid && req_mon.ready)
        awaited_responses.push_back(predict_frame_response(cmd_t'(req_mon.command),
                                                           req_mon.base_address,
                                                           req_mon.range_length));
    end
    mismatch_count <= errors;
    responses_due  <= awaited_responses.size();
  end

endmodule

[bench/tb_top.sv]
// Testbench top: clock, reset, request stimulus, response stalls and the final verdict.
`timescale 1ns / 1ps

module tb_top;
  import bfa_pkg::*;

  localparam int FRAME_BYTES     = DEF_FRAME_BYTES;
  localparam int MAX_FRAMES      = DEF_MAX_FRAMES;
  localparam int RANDOM_REQUESTS = 1925;
  localparam int LIMIT_CYCLES    = 20_000_000;
  localparam int TAIL_CYCLES     = 64;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  int               mismatch_count;
  int               responses_due;
  int               send_idle_pct  = 0;
  int               recv_stall_pct = 0;
  int               cycle_count    = 0;

  bfa_req_if req_chan ();
  bfa_rsp_if rsp_chan ();

  always #6 clk = ~clk;

  bitmap_frame_allocator u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (req_chan),
    .out_chan    (rsp_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  frame_map_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_mon        (req_chan),
    .rsp_mon        (rsp_chan),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatch_count (mismatch_count),
    .responses_due  (responses_due)
  );

  function automatic bit roll(input int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // Stall the response channel at random
  always @(negedge clk) rsp_chan.ready <= !roll(recv_stall_pct);

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("bitmap_frame_allocator verification failed");
      $finish;
    end
  end

  // Offer one request, idling first at random, and hold it until taken
  task automatic send_request(input cmd_t cmd, input logic [ADDR_W-1:0] base,
                              input logic [LEN_W-1:0] len);
    @(negedge clk);
    while (roll(send_idle_pct)) begin
      req_chan.valid        = 1'b0;
      req_chan.command      = CMD_W'($urandom_range(3, 0));
      req_chan.base_address = $urandom();
      req_chan.range_length = $urandom();
      @(negedge clk);
    end
    req_chan.valid        = 1'b1;
    req_chan.command      = cmd;
    req_chan.base_address = base;
    req_chan.range_length = len;
    @(posedge clk);
    while (!req_chan.ready) @(posedge clk);
  endtask

  // Drain every outstanding response, then write the frame limit
  task automatic write_limit(input logic [CFG_W-1:0] value);
    @(negedge clk);
    req_chan.valid = 1'b0;
    while (responses_due != 0) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] phase_limit(input int idx);
    case (idx % 11)
      0:       return 17'd64;
      1:       return 17'd1;
      2:       return 17'd4096;
      3:       return 17'd65536;
      4:       return 17'd100;
      5:       return 17'd0;
      6:       return 17'd131071;
      7:       return 17'd2048;
      8:       return 17'd65535;
      9:       return 17'd640;
      default: return 17'd3;
    endcase
  endfunction

  // Byte address inside the first window frames, sometimes anywhere
  function automatic logic [ADDR_W-1:0] pick_base(input int unsigned window);
    int unsigned sel;
    int unsigned frame;
    int unsigned offset;
    sel   = $urandom_range(99, 0);
    frame = $urandom_range(window - 1, 0);
    if (sel < 8) return $urandom();
    if (sel < 55) offset = 0;
    else if (sel < 80) offset = $urandom_range(FRAME_BYTES - 1, 0);
    else if (sel < 90) offset = FRAME_BYTES - 1;
    else offset = 1;
    return ADDR_W'(frame * FRAME_BYTES + offset);
  endfunction

  // Mostly short ranges, a few empty or huge ones
  function automatic logic [LEN_W-1:0] pick_length();
    int unsigned sel;
    sel = $urandom_range(99, 0);
    if (sel < 4) return $urandom();
    if (sel < 7) return '1;
    if (sel < 15) return '0;
    if (sel < 30) return $urandom_range(8, 1) * FRAME_BYTES;
    if (sel < 55) return $urandom_range(4 * FRAME_BYTES, 1);
    if (sel < 85) return $urandom_range(16 * FRAME_BYTES, 0);
    return $urandom_range(256 * FRAME_BYTES, 0);
  endfunction

  task automatic send_random_request(input int unsigned lim_eff);
    cmd_t        cmd;
    int unsigned sel;
    int unsigned window;
    sel = $urandom_range(99, 0);
    if (sel < 35) cmd = CMD_ALLOC;
    else if (sel < 60) cmd = CMD_FREE;
    else if (sel < 75) cmd = CMD_RESERVE;
    else cmd = CMD_RELEASE;
    // Keep most activity in low frames so alloc walks stay short
    if (lim_eff == 0) window = 64;
    else if (lim_eff > 2048 && !roll(15)) window = 2048;
    else window = lim_eff + 8;
    send_request(cmd, pick_base(window), pick_length());
  endtask

  initial begin
    logic [CFG_W-1:0] lim_word;
    int unsigned      lim_eff;
    int               sent;
    int               phase;
    int               count;

    rst_n                 = 1'b0;
    cfg_wr_en             = 1'b0;
    cfg_wr_data           = CFG_RESET;
    req_chan.valid        = 1'b0;
    req_chan.command      = CMD_ALLOC;
    req_chan.base_address = '0;
    req_chan.range_length = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed: map full after reset, single frames, rounding, clipping
    send_request(CMD_ALLOC,   32'h0000_0000, 32'h0000_0000);  // nothing free
    send_request(CMD_FREE,    32'h0000_0000, 32'h0000_0000);
    send_request(CMD_FREE,    32'h0000_0FFF, 32'h0000_0000);  // already free
    send_request(CMD_ALLOC,   32'hFFFF_FFFF, 32'hFFFF_FFFF);  // frame zero
    send_request(CMD_RELEASE, 32'h0000_0000, 32'h0000_0000);  // empty range
    send_request(CMD_RELEASE, 32'h0000_0001, 32'h0000_0FFF);  // rounds to nothing
    send_request(CMD_RELEASE, 32'h0000_0FFF, 32'h0000_1001);  // frees frame one
    send_request(CMD_RELEASE, 32'h0000_3001, 32'h0000_000A);  // inverted
    send_request(CMD_RESERVE, 32'h0000_1FFF, 32'h0000_0002);  // rounds outward
    send_request(CMD_RESERVE, 32'h0000_5000, 32'h0000_0000);
    send_request(CMD_FREE,    32'hFFFF_F000, 32'h0000_0000);  // above the limit
    send_request(CMD_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // end past 32 bits
    send_request(CMD_RELEASE, 32'h0000_0000, 32'hFFFF_FFFF);  // everything free
    send_request(CMD_ALLOC,   32'h0000_0000, 32'h0000_0000);
    send_request(CMD_RESERVE, 32'h0000_0000, 32'hFFFF_FFFF);  // everything used
    send_request(CMD_RELEASE, 32'h0001_0000, 32'h0000_8000);  // frames 16 to 23
    // Lower the limit below some free frames
    write_limit(17'd20);
    send_request(CMD_ALLOC,   32'h0000_0000, 32'h0000_0000);
    send_request(CMD_FREE,    32'h0001_5000, 32'h0000_0000);
    repeat (4) send_request(CMD_ALLOC, 32'h0000_0000, 32'h0000_0000);
    write_limit(17'd0);
    send_request(CMD_ALLOC,   32'h0000_0000, 32'h0000_0000);
    send_request(CMD_FREE,    32'h0000_0000, 32'h0000_0000);
    write_limit(17'd131071);
    send_request(CMD_ALLOC,   32'h0000_0000, 32'h0000_0000);

    // Random phases: a new limit and a new idling mix each phase
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_REQUESTS) begin
      if (phase % 5 == 4) lim_word = CFG_W'($urandom_range(8192, 1));
      else lim_word = phase_limit(phase);
      write_limit(lim_word);
      lim_eff = (lim_word > MAX_FRAMES) ? MAX_FRAMES : lim_word;
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      count = (lim_eff < 64) ? 25 : $urandom_range(130, 70);
      repeat (count) begin
        send_random_request(lim_eff);
        sent++;
      end
      phase++;
    end

    // Drop valid, wait out the responses and the tail
    @(negedge clk);
    req_chan.valid = 1'b0;
    while (responses_due != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0) begin
      $display("bitmap_frame_allocator verification clean");
    end else begin
      $display("bitmap_frame_allocator verification failed");
    end
    $finish;
  end

endmodule

[bitmap_frame_allocator.f]
rtl/core/bfa_pkg.sv
rtl/core/bfa_if.sv
rtl/core/bfa_ram.sv
rtl/core/bfa_word_unit.sv
rtl/core/bitmap_frame_allocator.sv
bench/frame_map_checker.sv
bench/tb_top.sv
